// File: hw/rtl/inverse_cdf_sampler_unit_defines.svh
// assertion helpers, clocked on clk_i and disabled while rst_ni is low
`ifndef INVERSE_CDF_SAMPLER_UNIT_DEFINES_SVH
`define INVERSE_CDF_SAMPLER_UNIT_DEFINES_SVH

// property that must hold in the same cycle
`define ICDF_ASSERT_NOW(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ICDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/icdf_pkg.sv
package icdf_pkg;

  localparam int unsigned CFG_W  = 7;
  localparam int unsigned BIN_W  = 6;
  localparam int unsigned PROB_W = 17;
  localparam int unsigned VAL_W  = 24;
  localparam int unsigned U_W    = 16;
  localparam int unsigned SEG_W  = 7;

  // divider operand widths: |du * dv| < 2^41, |dp| < 2^17
  localparam int unsigned NUM_W  = 41;
  localparam int unsigned DEN_W  = 17;
  // wide signed sum ahead of saturation
  localparam int unsigned SUM_W  = 44;

  localparam logic [CFG_W-1:0]  MIN_BINS = 7'd2;
  localparam logic [CFG_W-1:0]  CFG_RST  = 7'd2;
  localparam logic [PROB_W-1:0] ONE_Q16  = 17'd65536;
  localparam logic [PROB_W-1:0] SUM_MAX  = 17'd131071;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic [PROB_W-1:0]       prob;
    logic signed [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] x);
    logic [SUM_W-VAL_W:0] upper;
    logic [VAL_W-1:0]     res;
    upper = x[SUM_W-1:VAL_W-1];
    if (upper == '0 || upper == '1) begin
      res = x[VAL_W-1:0];
    end else if (x[SUM_W-1]) begin
      res = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(VAL_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/icdf_if.sv
interface icdf_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   opcode;
  logic [icdf_pkg::BIN_W-1:0]             bin_index;
  logic [icdf_pkg::PROB_W-1:0]            bin_probability;
  logic signed [icdf_pkg::VAL_W-1:0]      bin_value;
  logic [icdf_pkg::U_W-1:0]               uniform_variate;

  modport source (output valid, opcode, bin_index, bin_probability, bin_value,
                  uniform_variate, input ready);
  modport sink   (input valid, opcode, bin_index, bin_probability, bin_value,
                  uniform_variate, output ready);
endinterface

interface icdf_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [icdf_pkg::VAL_W-1:0]      sample_value;
  logic [icdf_pkg::SEG_W-1:0]             segment_index;
  logic                                   table_error;

  modport source (output valid, sample_value, segment_index, table_error, input ready);
  modport sink   (input valid, sample_value, segment_index, table_error, output ready);
endinterface

// File: hw/rtl/icdf_ram.sv
module icdf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/icdf_div.sv
module icdf_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  icdf_pkg::div_req_t req_i,
  output icdf_pkg::div_rsp_t rsp_o
);

  localparam int unsigned NUM_W = icdf_pkg::NUM_W;
  localparam int unsigned DEN_W = icdf_pkg::DEN_W;
  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] trial;

  // restoring division, one quotient bit per cycle, dividend shifts out of quo_q
  assign rem_sh = {rem_q, quo_q[NUM_W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(NUM_W - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      den_q <= req_i.den;
      quo_q <= req_i.num;
    end else if (busy_q) begin
      if (!trial[DEN_W+1]) begin
        rem_q <= trial[DEN_W-1:0];
        quo_q <= {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DEN_W-1:0];
        quo_q <= {quo_q[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

// File: hw/rtl/inverse_cdf_sampler_unit.sv
// inverse transform sampler over a piecewise linear cdf table
// in_i carries load transactions (opcode 0: bin index, probability, centre value)
// and sample transactions (opcode 1: uniform variate); out_o returns one result
// transaction per input transaction, in order. cfg_we_i/cfg_wdata_i set the bin
// count n; the user must write it only while idle, the block does not enforce it.
// one transaction is worked on at a time; in_i.ready is high when the block is idle.
// a load goes straight to the result; the load of the last bin first runs the
// bit-serial divider for the half width of the edge points and writes both edges.
// a sample: the table scan reads one entry per cycle through the single read port
// of the table memory, then, unless the segment has zero probability width, the
// same divider produces the interpolation fraction.
// results sit in an output register: the next transaction is accepted while a
// result waits; if out_o.ready stays low the block holds its next result until
// the register frees up.
// reset clears the running sum, the error flag and sets n to 2; the table itself
// is not cleared and must be loaded completely before sampling.
`include "inverse_cdf_sampler_unit_defines.svh"

module inverse_cdf_sampler_unit #(
  parameter int unsigned MAX_BINS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [icdf_pkg::CFG_W-1:0] cfg_wdata_i,
  icdf_in_if.sink                    in_i,
  icdf_out_if.source                 out_o
);

  localparam int unsigned DEPTH  = MAX_BINS + 2;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned ENT_W  = $bits(icdf_pkg::entry_t);
  localparam int unsigned CFG_W  = icdf_pkg::CFG_W;
  localparam int unsigned PROB_W = icdf_pkg::PROB_W;
  localparam int unsigned VAL_W  = icdf_pkg::VAL_W;
  localparam int unsigned SUM_W  = icdf_pkg::SUM_W;
  localparam int unsigned NUM_W  = icdf_pkg::NUM_W;
  localparam int unsigned DEN_W  = icdf_pkg::DEN_W;
  localparam int unsigned PROD_W = (PROB_W + 1) + (VAL_W + 1);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_LDRD = 10'b0000000010,
    S_HALF = 10'b0000000100,
    S_WRLO = 10'b0000001000,
    S_WRHI = 10'b0000010000,
    S_SRCH = 10'b0000100000,
    S_MUL  = 10'b0001000000,
    S_QST  = 10'b0010000000,
    S_QDIV = 10'b0100000000,
    S_RES  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [CFG_W-1:0]  cfg_q;
  logic [CFG_W-1:0]  n;
  logic [PROB_W-1:0] sum_q, sum_d;
  logic              err_q, err_d;

  logic [ADDR_W-1:0] idx_q;
  logic [ADDR_W-1:0] last_idx;
  logic [icdf_pkg::U_W-1:0] u_q;
  icdf_pkg::entry_t  lo_q, hi_q;
  logic [ADDR_W-1:0] seg_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROB_W:0]   den_q;
  logic              neg_q;
  logic signed [VAL_W:0]    half_q;
  logic signed [VAL_W-1:0]  res_val_q;
  logic [icdf_pkg::SEG_W-1:0] res_seg_q;

  logic              out_valid_q;
  logic signed [VAL_W-1:0]  out_val_q;
  logic [icdf_pkg::SEG_W-1:0] out_seg_q;
  logic              out_err_q;

  logic              in_fire, out_fire, res_move;
  logic              is_load, ld_ok, ld_last;
  logic [PROB_W:0]   sum_add;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  icdf_pkg::entry_t  ram_wdata, ram_rdata;

  icdf_pkg::div_req_t div_req;
  icdf_pkg::div_rsp_t div_rsp;

  logic              found;
  logic signed [PROB_W:0]   du;
  logic signed [VAL_W:0]    dv;
  logic signed [VAL_W:0]    mid_sum;
  logic signed [VAL_W:0]    ld_diff;
  logic [VAL_W:0]           ld_abs;
  logic [PROD_W-1:0]        prod_abs;
  logic [PROB_W:0]          den_abs;
  logic signed [NUM_W:0]    q_signed;
  logic signed [VAL_W:0]    half_d;

  // effective bin count
  always_comb begin
    n = cfg_q;
    if (cfg_q < icdf_pkg::MIN_BINS) begin
      n = icdf_pkg::MIN_BINS;
    end else if (32'(cfg_q) > MAX_BINS) begin
      n = CFG_W'(MAX_BINS);
    end
  end

  assign last_idx = ADDR_W'(n) + ADDR_W'(1);

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_o.valid && out_o.ready;
  assign res_move   = (state_q == S_RES) && (!out_valid_q || out_o.ready);

  assign is_load = (in_i.opcode == icdf_pkg::OP_LOAD);
  assign ld_ok   = CFG_W'(in_i.bin_index) < n;
  assign ld_last = ld_ok && (CFG_W'(in_i.bin_index) == n - CFG_W'(1));

  // running sum: restart on bin zero, otherwise saturating add
  assign sum_add = {1'b0, sum_q} + {1'b0, in_i.bin_probability};
  always_comb begin
    sum_d = sum_q;
    err_d = err_q;
    if (in_fire && is_load && ld_ok) begin
      if (in_i.bin_index == '0) begin
        sum_d = in_i.bin_probability;
      end else if (sum_add > {1'b0, icdf_pkg::SUM_MAX}) begin
        sum_d = icdf_pkg::SUM_MAX;
      end else begin
        sum_d = sum_add[PROB_W-1:0];
      end
      if (sum_d > icdf_pkg::ONE_Q16) begin
        err_d = 1'b1;
      end
    end
  end

  // segment found when prev prob <= u <= current prob, or the scan reaches the last entry
  assign found = (idx_q != '0) &&
                 (({1'b0, u_q} >= lo_q.prob && {1'b0, u_q} <= ram_rdata.prob) ||
                  idx_q == last_idx);

  assign du = $signed({2'b00, u_q}) - $signed({1'b0, lo_q.prob});
  assign dv = $signed({hi_q.value[VAL_W-1], hi_q.value}) -
              $signed({lo_q.value[VAL_W-1], lo_q.value});
  assign mid_sum = $signed({hi_q.value[VAL_W-1], hi_q.value}) +
                   $signed({lo_q.value[VAL_W-1], lo_q.value});

  assign ld_diff  = $signed({hi_q.value[VAL_W-1], hi_q.value}) -
                    $signed({ram_rdata.value[VAL_W-1], ram_rdata.value});
  assign ld_abs   = ld_diff[VAL_W] ? VAL_W'(1) + ~ld_diff : ld_diff;
  assign prod_abs = prod_q[PROD_W-1] ? -prod_q : prod_q;
  assign den_abs  = den_q[PROB_W] ? -den_q : den_q;

  assign q_signed = neg_q ? -$signed({1'b0, div_rsp.quot}) : $signed({1'b0, div_rsp.quot});
  assign half_d   = neg_q ? -$signed(div_rsp.quot[VAL_W:0]) : $signed(div_rsp.quot[VAL_W:0]);

  // divider requests: edge half width and interpolation fraction
  always_comb begin
    div_req.start = (state_q == S_LDRD) || (state_q == S_QST);
    if (state_q == S_LDRD) begin
      div_req.num = NUM_W'(ld_abs);
      div_req.den = DEN_W'({n - CFG_W'(1), 1'b0});
    end else begin
      div_req.num = prod_abs[NUM_W-1:0];
      div_req.den = den_abs[DEN_W-1:0];
    end
  end

  // table memory ports
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state_q)
      S_IDLE: begin
        if (in_fire && is_load && ld_ok) begin
          ram_we          = 1'b1;
          ram_waddr       = ADDR_W'(CFG_W'(in_i.bin_index) + CFG_W'(1));
          ram_wdata.prob  = sum_d;
          ram_wdata.value = in_i.bin_value;
        end
        if (in_fire && is_load && ld_last) begin
          ram_re    = 1'b1;
          ram_raddr = ADDR_W'(1);
        end
        if (in_fire && !is_load) begin
          ram_re    = 1'b1;
          ram_raddr = '0;
        end
      end
      S_WRLO: begin
        ram_we          = 1'b1;
        ram_waddr       = '0;
        ram_wdata.prob  = '0;
        ram_wdata.value = icdf_pkg::sat_val(SUM_W'($signed(lo_q.value)) - SUM_W'(half_q));
      end
      S_WRHI: begin
        ram_we          = 1'b1;
        ram_waddr       = last_idx;
        ram_wdata.prob  = icdf_pkg::ONE_Q16;
        ram_wdata.value = icdf_pkg::sat_val(SUM_W'($signed(hi_q.value)) + SUM_W'(half_q));
      end
      S_SRCH: begin
        if (!found) begin
          ram_re    = 1'b1;
          ram_raddr = idx_q + ADDR_W'(1);
        end
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (!is_load) begin
            state_d = S_SRCH;
          end else if (ld_last) begin
            state_d = S_LDRD;
          end else begin
            state_d = S_RES;
          end
        end
      end
      S_LDRD: state_d = S_HALF;
      S_HALF: begin
        if (div_rsp.done) begin
          state_d = S_WRLO;
        end
      end
      S_WRLO: state_d = S_WRHI;
      S_WRHI: state_d = S_RES;
      S_SRCH: begin
        if (found) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        if (lo_q.prob == hi_q.prob) begin
          state_d = S_RES;
        end else begin
          state_d = S_QST;
        end
      end
      S_QST: state_d = S_QDIV;
      S_QDIV: begin
        if (div_rsp.done) begin
          state_d = S_RES;
        end
      end
      S_RES: begin
        if (res_move) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_q       <= icdf_pkg::CFG_RST;
      sum_q       <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      err_q   <= err_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (res_move) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          u_q          <= in_i.uniform_variate;
          idx_q        <= '0;
          hi_q.value   <= in_i.bin_value;
          res_val_q    <= '0;
          res_seg_q    <= '0;
        end
      end
      S_LDRD: begin
        lo_q  <= ram_rdata;
        neg_q <= ld_diff[VAL_W];
      end
      S_HALF: begin
        if (div_rsp.done) begin
          half_q <= half_d;
        end
      end
      S_SRCH: begin
        if (found) begin
          hi_q  <= ram_rdata;
          seg_q <= idx_q;
        end else begin
          lo_q  <= ram_rdata;
          idx_q <= idx_q + ADDR_W'(1);
        end
      end
      S_MUL: begin
        prod_q    <= du * dv;
        den_q     <= $signed({1'b0, hi_q.prob}) - $signed({1'b0, lo_q.prob});
        res_val_q <= mid_sum[VAL_W:1];
        res_seg_q <= icdf_pkg::SEG_W'(seg_q);
      end
      S_QST: begin
        neg_q <= prod_q[PROD_W-1] ^ den_q[PROB_W];
      end
      S_QDIV: begin
        if (div_rsp.done) begin
          res_val_q <= icdf_pkg::sat_val(SUM_W'($signed(lo_q.value)) + SUM_W'(q_signed));
        end
      end
      default: begin
      end
    endcase
    if (res_move) begin
      out_val_q <= res_val_q;
      out_seg_q <= res_seg_q;
      out_err_q <= err_q;
    end
  end

  icdf_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  icdf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_o.valid         = out_valid_q;
  assign out_o.sample_value  = out_val_q;
  assign out_o.segment_index = out_seg_q;
  assign out_o.table_error   = out_err_q;

  `ICDF_ASSERT_NEXT(a_one_at_a_time, in_fire, !in_i.ready, "transaction accepted while busy")
  `ICDF_ASSERT_NOW(a_div_done_waited, !div_rsp.done || state_q == S_HALF || state_q == S_QDIV,
                   "divider result with no consumer")
  `ICDF_ASSERT_NOW(a_scan_in_table, state_q != S_SRCH || idx_q <= last_idx,
                   "table scan ran past the last entry")
  `ICDF_ASSERT_NEXT(a_error_sticky, err_q, err_q, "error flag cleared")

endmodule
